>>> rtl/core/sma_pkg.sv
// shared constants and types for the spectrum magnitude averager
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package sma_pkg;

   localparam int TIME_SIZE = 1024;
   localparam int SPEC_BINS = TIME_SIZE / 2 + 1;
   localparam int MAX_BANDS = SPEC_BINS / 2;

   localparam int PART_W   = 24;
   localparam int BIN_W    = 10;
   localparam int NAV_W    = 9;
   localparam int BIDX_W   = 8;
   localparam int MAG_W    = 24;
   localparam int SQ_W     = 48;
   localparam int SUM_W    = 34;
   localparam int REM_W    = 27;
   localparam int STEP_W   = 5;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   localparam logic [STEP_W-1:0] ROOT_STEPS  = STEP_W'(MAG_W);
   localparam logic [STEP_W-1:0] WIDTH_STEPS = STEP_W'(BIN_W);
   localparam logic [STEP_W-1:0] AVG_STEPS   = STEP_W'(SUM_W - BIN_W);

   localparam logic [BIN_W-1:0] SPEC_BINS_V = BIN_W'(SPEC_BINS);
   localparam logic [BIN_W-1:0] LAST_BIN_V  = BIN_W'(SPEC_BINS - 1);
   localparam logic [NAV_W-1:0] MAX_BANDS_V = NAV_W'(MAX_BANDS);

   localparam logic REG_AVERAGE_MODE = 1'b0;
   localparam logic REG_NUM_AVERAGES = 1'b1;

   typedef struct packed {
      logic              sqrt_mode;
      logic [REM_W-1:0]  rem;
      logic [1:0]        next_bits;
      logic [MAG_W-1:0]  root;
      logic [BIN_W-1:0]  divisor;
   } step_req_type;

   typedef struct packed {
      logic              take;
      logic [REM_W-1:0]  rem;
   } step_rsp_type;

endpackage

>>> rtl/core/sma_step.sv
// shared compare and subtract step for square root and division
// depends on sma_pkg
`timescale 1ns / 1ps

module sma_step
   import sma_pkg::*;
(
   input  step_req_type req,
   output step_rsp_type rsp
);

   logic [REM_W-1:0] trial_a;
   logic [REM_W-1:0] trial_b;
   logic [REM_W:0]   diff;

   always_comb begin
      if (req.sqrt_mode) begin
         trial_a = {req.rem[REM_W-3:0], req.next_bits};
         trial_b = {1'b0, req.root, 2'b01};
      end else begin
         trial_a = {req.rem[REM_W-2:0], req.next_bits[1]};
         trial_b = {{(REM_W-BIN_W){1'b0}}, req.divisor};
      end
      diff     = {1'b0, trial_a} - {1'b0, trial_b};
      rsp.take = ~diff[REM_W];
      rsp.rem  = rsp.take ? diff[REM_W-1:0] : trial_a;
   end

endmodule

>>> rtl/core/spectrum_magnitude_averager.sv
// top level of the spectrum magnitude averager: sequencer, band state, csr port
// depends on sma_pkg and sma_step
`timescale 1ns / 1ps
//
// One FFT bin word enters on the req channel (valid/ready) in order 0 .. TIME_SIZE/2;
// first_bin restarts the bin and band counters. Each bin gives one rsp word with its
// index, floor magnitude, last_bin flag and, in linear mode, the band average when the
// bin closes a band of (TIME_SIZE/2+1)/num_averages bins.
// One compare/subtract unit does all the work, one step a cycle: 24 steps of square
// root, 10 steps of band width division at bin zero, 24 steps of band mean division at
// a band's last bin. Squares come from one 24x24 multiplier, real part then imaginary part.
// Each bin passes through band width division (bin zero only), squaring of the real and
// imaginary parts, square root, band update, band mean division (when a band completes
// in linear mode) and finish. req_ready is high only while the sequencer is idle.
// The result sits in an output register, so the next bin is accepted while it waits;
// if the receiver stalls, the following bin is held finished until the register frees.
// Registers (APB, pready always high): 0x0 average_mode, 0x4 num_averages; a write of
// num_averages outside 1 .. TIME_SIZE/4 is dropped. Write only while idle.
// Synchronous reset clears all control state, average_mode to 0 and num_averages to 1.
//

module spectrum_magnitude_averager
   import sma_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [PART_W-1:0] req_real_part,
   input  logic signed [PART_W-1:0] req_imag_part,
   input  logic                     req_first_bin,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [BIN_W-1:0]         rsp_bin_index,
   output logic [MAG_W-1:0]         rsp_magnitude,
   output logic                     rsp_band_valid,
   output logic [BIDX_W-1:0]        rsp_band_index,
   output logic [MAG_W-1:0]         rsp_band_average,
   output logic                     rsp_last_bin,

   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [ADDR_W-1:0]        paddr,
   input  logic [DATA_W-1:0]        pwdata,
   output logic [DATA_W-1:0]        prdata,
   output logic                     pready
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_WIDTH  = 8'b0000_0010,
      ST_SQ_RE  = 8'b0000_0100,
      ST_SQ_IM  = 8'b0000_1000,
      ST_ROOT   = 8'b0001_0000,
      ST_BAND   = 8'b0010_0000,
      ST_AVG    = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic              mode_ff, mode_in;
   logic [NAV_W-1:0]  num_av_ff, num_av_in;

   logic [BIN_W-1:0]  bin_count_ff, bin_count_in;
   logic [NAV_W-1:0]  band_count_ff, band_count_in;
   logic [BIN_W-1:0]  in_band_ff, in_band_in;
   logic [SUM_W-1:0]  band_sum_ff, band_sum_in;
   logic [BIN_W-1:0]  band_width_ff, band_width_in;

   logic [PART_W-1:0] re_ff, re_in;
   logic [PART_W-1:0] im_ff, im_in;
   logic [BIN_W-1:0]  idx_ff, idx_in;
   logic [SQ_W-1:0]   x_ff, x_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [MAG_W-1:0]  q_ff, q_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic              bvalid_ff, bvalid_in;
   logic [BIDX_W-1:0] bidx_ff, bidx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BIN_W-1:0]  rsp_bin_ff, rsp_bin_in;
   logic [MAG_W-1:0]  rsp_mag_ff, rsp_mag_in;
   logic              rsp_bvalid_ff, rsp_bvalid_in;
   logic [BIDX_W-1:0] rsp_bidx_ff, rsp_bidx_in;
   logic [MAG_W-1:0]  rsp_bavg_ff, rsp_bavg_in;
   logic              rsp_last_ff, rsp_last_in;

   step_req_type      step_req;
   step_rsp_type      step_rsp;

   logic [PART_W-1:0] mul_op;
   logic [SQ_W-1:0]   mul_prod;
   logic [BIN_W-1:0]  idx_now;
   logic [SUM_W-1:0]  sum_next;
   logic [BIN_W-1:0]  in_band_next;
   logic              cfg_write;
   logic [NAV_W-1:0]  wr_nav;

   sma_step u_step (
      .req (step_req),
      .rsp (step_rsp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;
   assign wr_nav    = pwdata[NAV_W-1:0];
   assign prdata    = (paddr[2] == REG_NUM_AVERAGES) ?
                      {{(DATA_W-NAV_W){1'b0}}, num_av_ff} :
                      {{(DATA_W-1){1'b0}}, mode_ff};

   assign mul_op   = (state_ff == ST_SQ_RE) ? re_ff : im_ff;
   assign mul_prod = {{PART_W{1'b0}}, mul_op} * {{PART_W{1'b0}}, mul_op};

   assign idx_now      = req_first_bin ? '0 : bin_count_ff;
   assign sum_next     = band_sum_ff + {{(SUM_W-MAG_W){1'b0}}, q_ff};
   assign in_band_next = in_band_ff + 1'b1;

   always_comb begin
      step_req.sqrt_mode = (state_ff == ST_ROOT);
      step_req.rem       = rem_ff;
      step_req.next_bits = x_ff[SQ_W-1 -: 2];
      step_req.root      = q_ff;
      step_req.divisor   = (state_ff == ST_WIDTH) ? {1'b0, num_av_ff} : band_width_ff;
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      num_av_in     = num_av_ff;
      bin_count_in  = bin_count_ff;
      band_count_in = band_count_ff;
      in_band_in    = in_band_ff;
      band_sum_in   = band_sum_ff;
      band_width_in = band_width_ff;
      re_in         = re_ff;
      im_in         = im_ff;
      idx_in        = idx_ff;
      x_in          = x_ff;
      rem_in        = rem_ff;
      q_in          = q_ff;
      cnt_in        = cnt_ff;
      mag_in        = mag_ff;
      bvalid_in     = bvalid_ff;
      bidx_in       = bidx_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_bin_in    = rsp_bin_ff;
      rsp_mag_in    = rsp_mag_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_bidx_in   = rsp_bidx_ff;
      rsp_bavg_in   = rsp_bavg_ff;
      rsp_last_in   = rsp_last_ff;

      if (cfg_write) begin
         if (paddr[2] == REG_AVERAGE_MODE) begin
            mode_in = pwdata[0];
         end else if (wr_nav != '0 && wr_nav <= MAX_BANDS_V) begin
            num_av_in = wr_nav;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               re_in        = req_real_part[PART_W-1] ? PART_W'(0) - req_real_part
                                                      : req_real_part;
               im_in        = req_imag_part[PART_W-1] ? PART_W'(0) - req_imag_part
                                                      : req_imag_part;
               idx_in       = idx_now;
               bin_count_in = (idx_now == LAST_BIN_V) ? '0 : idx_now + 1'b1;
               bvalid_in    = 1'b0;
               bidx_in      = '0;
               if (idx_now == '0) begin
                  band_count_in = '0;
                  in_band_in    = '0;
                  band_sum_in   = '0;
                  x_in          = {SPEC_BINS_V, {(SQ_W-BIN_W){1'b0}}};
                  rem_in        = '0;
                  cnt_in        = WIDTH_STEPS - 1'b1;
                  state_in      = ST_WIDTH;
               end else begin
                  state_in = ST_SQ_RE;
               end
            end
         end
         ST_WIDTH: begin
            rem_in = step_rsp.rem;
            q_in   = {q_ff[MAG_W-2:0], step_rsp.take};
            x_in   = {x_ff[SQ_W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               band_width_in = q_in[BIN_W-1:0];
               state_in      = ST_SQ_RE;
            end
         end
         ST_SQ_RE: begin
            x_in     = mul_prod;
            state_in = ST_SQ_IM;
         end
         ST_SQ_IM: begin
            x_in     = x_ff + mul_prod;
            rem_in   = '0;
            q_in     = '0;
            cnt_in   = ROOT_STEPS - 1'b1;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rem_in = step_rsp.rem;
            q_in   = {q_ff[MAG_W-2:0], step_rsp.take};
            x_in   = {x_ff[SQ_W-3:0], 2'b00};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_BAND;
            end
         end
         ST_BAND: begin
            mag_in   = q_ff;
            state_in = ST_FINISH;
            if (band_count_ff < num_av_ff) begin
               if (in_band_next >= band_width_ff) begin
                  if (mode_ff) begin
                     bvalid_in = 1'b1;
                     bidx_in   = band_count_ff[BIDX_W-1:0];
                     rem_in    = {{(REM_W-BIN_W){1'b0}}, sum_next[SUM_W-1 -: BIN_W]};
                     x_in      = {sum_next[MAG_W-1:0], {(SQ_W-MAG_W){1'b0}}};
                     cnt_in    = AVG_STEPS - 1'b1;
                     state_in  = ST_AVG;
                  end
                  band_count_in = band_count_ff + 1'b1;
                  in_band_in    = '0;
                  band_sum_in   = '0;
               end else begin
                  in_band_in  = in_band_next;
                  band_sum_in = sum_next;
               end
            end
         end
         ST_AVG: begin
            rem_in = step_rsp.rem;
            q_in   = {q_ff[MAG_W-2:0], step_rsp.take};
            x_in   = {x_ff[SQ_W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_bin_in    = idx_ff;
               rsp_mag_in    = mag_ff;
               rsp_bvalid_in = bvalid_ff;
               rsp_bidx_in   = bidx_ff;
               rsp_bavg_in   = bvalid_ff ? q_ff : '0;
               rsp_last_in   = (idx_ff == LAST_BIN_V);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= 1'b0;
         num_av_ff     <= NAV_W'(1);
         bin_count_ff  <= '0;
         band_count_ff <= '0;
         in_band_ff    <= '0;
         band_sum_ff   <= '0;
         band_width_ff <= SPEC_BINS_V;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         num_av_ff     <= num_av_in;
         bin_count_ff  <= bin_count_in;
         band_count_ff <= band_count_in;
         in_band_ff    <= in_band_in;
         band_sum_ff   <= band_sum_in;
         band_width_ff <= band_width_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      re_ff         <= re_in;
      im_ff         <= im_in;
      idx_ff        <= idx_in;
      x_ff          <= x_in;
      rem_ff        <= rem_in;
      q_ff          <= q_in;
      cnt_ff        <= cnt_in;
      mag_ff        <= mag_in;
      bvalid_ff     <= bvalid_in;
      bidx_ff       <= bidx_in;
      rsp_bin_ff    <= rsp_bin_in;
      rsp_mag_ff    <= rsp_mag_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_bidx_ff   <= rsp_bidx_in;
      rsp_bavg_ff   <= rsp_bavg_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bin_index    = rsp_bin_ff;
   assign rsp_magnitude    = rsp_mag_ff;
   assign rsp_band_valid   = rsp_bvalid_ff;
   assign rsp_band_index   = rsp_bidx_ff;
   assign rsp_band_average = rsp_bavg_ff;
   assign rsp_last_bin     = rsp_last_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("block accepted a word while busy");

   a_bin_count_range: assert property (@(posedge clock) disable iff (reset)
      bin_count_ff < SPEC_BINS_V)
      else $error("bin count past spectrum end");

   a_in_band_below_width: assert property (@(posedge clock) disable iff (reset)
      in_band_ff < band_width_ff)
      else $error("band fill reached band width");

   a_no_band_fields_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_band_valid |-> rsp_band_index == '0 && rsp_band_average == '0)
      else $error("band fields set without band_valid");

   a_finish_loads_output: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && (!rsp_valid_ff || rsp_ready) |=> rsp_valid && req_ready)
      else $error("finished word not presented");

endmodule
